### rtl/sfl_pkg.sv
`timescale 1ns / 1ps

package sfl_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int ID_W        = 4;
  localparam int CNT_W       = 5;
  localparam int RESET_SLOTS = (16 < MAX_SLOTS) ? 16 : MAX_SLOTS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_TAKE = 2'd0;
  localparam logic [1:0] ACT_GIVE = 2'd1;
  localparam logic [1:0] ACT_PEAK = 2'd2;

  typedef enum logic [1:0] {
    OP_TAKE = 2'd0,
    OP_GIVE = 2'd1,
    OP_PEAK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] slot_id;
  } cmd_t;

  typedef struct packed {
    logic             granted;
    logic [ID_W-1:0]  granted_id;
    logic             dropped;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] active_count;
    logic [CNT_W-1:0] peak_active;
  } res_t;

  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] p);
    ring_next = (p == ID_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] active_of(input logic [CNT_W-1:0] slots,
                                                 input logic [CNT_W-1:0] free);
    active_of = (slots >= free) ? slots - free : '0;
  endfunction

endpackage

### rtl/sfl_if.sv
`timescale 1ns / 1ps

interface sfl_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [sfl_pkg::ID_W-1:0] slot_id;

  modport source (output valid, action, slot_id, input ready);
  modport sink   (input valid, action, slot_id, output ready);
endinterface

interface sfl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic [sfl_pkg::ID_W-1:0]  granted_id;
  logic                      dropped;
  logic [sfl_pkg::CNT_W-1:0] free_count;
  logic [sfl_pkg::CNT_W-1:0] active_count;
  logic [sfl_pkg::CNT_W-1:0] peak_active;

  modport source (output valid, granted, granted_id, dropped, free_count, active_count,
                  peak_active, input ready);
  modport sink   (input valid, granted, granted_id, dropped, free_count, active_count,
                  peak_active, output ready);
endinterface

interface sfl_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sfl_pkg::CNT_W-1:0] pool_size;

  modport source (output valid, pool_size, input ready);
  modport sink   (input valid, pool_size, output ready);
endinterface

### rtl/sfl_front.sv
`timescale 1ns / 1ps

module sfl_front (
  sfl_in_if.sink        in_ch,
  output logic          push_valid,
  output sfl_pkg::cmd_t push_cmd,
  input  logic          push_ready
);

  sfl_pkg::op_t op;

  always_comb begin
    unique case (in_ch.action)
      sfl_pkg::ACT_TAKE: op = sfl_pkg::OP_TAKE;
      sfl_pkg::ACT_GIVE: op = sfl_pkg::OP_GIVE;
      sfl_pkg::ACT_PEAK: op = sfl_pkg::OP_PEAK;
      default:           op = sfl_pkg::OP_NONE;
    endcase
  end

  assign push_valid       = in_ch.valid;
  assign push_cmd.op      = op;
  assign push_cmd.slot_id = in_ch.slot_id;
  assign in_ch.ready      = push_ready;

endmodule

### rtl/sfl_queue.sv
`timescale 1ns / 1ps

module sfl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  sfl_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output sfl_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);

  localparam int PTR_W = $clog2(sfl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sfl_pkg::QUEUE_DEPTH + 1);

  sfl_pkg::cmd_t     entry_r [sfl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != CNT_W'(sfl_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(sfl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(sfl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(sfl_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_then_less: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

  a_push_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1) && pop_valid)
    else $error("queue count did not rise on push");

endmodule

### rtl/sfl_back.sv
`timescale 1ns / 1ps

module sfl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sfl_pkg::cmd_t q_cmd,
  output logic          q_ready,
  sfl_cfg_if.sink       cfg_ch,
  sfl_out_if.source     out_ch
);

  localparam int ID_W  = sfl_pkg::ID_W;
  localparam int CNT_W = sfl_pkg::CNT_W;
  localparam int SLOTS = sfl_pkg::MAX_SLOTS;

  logic [ID_W-1:0]  ring_r [SLOTS];
  logic [SLOTS-1:0] filled_r, filled_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] slots_r, slots_nxt;
  logic             out_valid_r;
  sfl_pkg::res_t    out_r, res;

  logic             pop, cfg_we, refill, ring_we;
  logic [CNT_W-1:0] cfg_sat, act_take;

  assign q_ready      = !out_valid_r || out_ch.ready;
  assign pop          = q_valid && q_ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;
  assign cfg_sat      = (cfg_ch.pool_size > CNT_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                           : cfg_ch.pool_size;
  // a zero count is ignored
  assign refill       = cfg_we && (cfg_ch.pool_size != '0);
  assign act_take     = sfl_pkg::active_of(slots_r, free_r - 1'b1);

  always_comb begin
    filled_nxt = filled_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    peak_nxt   = peak_r;
    slots_nxt  = slots_r;
    ring_we    = 1'b0;
    res        = '0;
    if (pop) begin
      unique case (q_cmd.op)
        sfl_pkg::OP_TAKE: begin
          if (free_r != '0) begin
            res.granted    = 1'b1;
            // never-written entries still hold their refill id
            res.granted_id = filled_r[head_r] ? ring_r[head_r] : head_r;
            head_nxt       = sfl_pkg::ring_next(head_r);
            free_nxt       = free_r - 1'b1;
            if (act_take > peak_r) begin
              peak_nxt = act_take;
            end
          end
        end
        sfl_pkg::OP_GIVE: begin
          if (free_r >= CNT_W'(SLOTS)) begin
            res.dropped = 1'b1;
          end else begin
            ring_we              = 1'b1;
            filled_nxt[tail_r]   = 1'b1;
            tail_nxt             = sfl_pkg::ring_next(tail_r);
            free_nxt             = free_r + 1'b1;
          end
        end
        sfl_pkg::OP_PEAK: ;
        sfl_pkg::OP_NONE: ;
        default: ;
      endcase
      res.free_count   = free_nxt;
      res.active_count = sfl_pkg::active_of(slots_r, free_nxt);
      res.peak_active  = peak_nxt;
      if (q_cmd.op == sfl_pkg::OP_PEAK) begin
        peak_nxt = '0;
      end
    end
    if (refill) begin
      ring_we    = 1'b0;
      filled_nxt = '0;
      head_nxt   = '0;
      tail_nxt   = cfg_sat[ID_W-1:0];
      free_nxt   = cfg_sat;
      peak_nxt   = '0;
      slots_nxt  = cfg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      head_r      <= '0;
      tail_r      <= ID_W'(sfl_pkg::RESET_SLOTS % SLOTS);
      free_r      <= CNT_W'(sfl_pkg::RESET_SLOTS);
      peak_r      <= '0;
      slots_r     <= CNT_W'(sfl_pkg::RESET_SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      filled_r <= filled_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      free_r   <= free_nxt;
      peak_r   <= peak_nxt;
      slots_r  <= slots_nxt;
      if (q_ready) begin
        out_valid_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_r[tail_r] <= q_cmd.slot_id;
    end
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = out_r.granted;
  assign out_ch.granted_id   = out_r.granted_id;
  assign out_ch.dropped      = out_r.dropped;
  assign out_ch.free_count   = out_r.free_count;
  assign out_ch.active_count = out_r.active_count;
  assign out_ch.peak_active  = out_r.peak_active;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CNT_W'(SLOTS))
    else $error("free total above pool depth");

  a_take_grants: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.op == sfl_pkg::OP_TAKE && free_r != '0)
      |=> out_valid_r && out_r.granted && (free_r == $past(free_r) - 1'b1
                                           || $past(refill)))
    else $error("take with free slots gave no grant");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !refill && q_cmd.op == sfl_pkg::OP_GIVE && free_r == CNT_W'(SLOTS))
      |=> out_r.dropped && free_r == CNT_W'(SLOTS))
    else $error("give to full list not dropped");

  a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_cmd.op == sfl_pkg::OP_PEAK) |=> peak_r == '0)
    else $error("peak read did not clear the mark");

endmodule

### rtl/slot_free_list_allocator_top.sv
`timescale 1ns / 1ps

// Slot free-list allocator: a FIFO ring of free slot ids with a high-water mark
// of active slots. Each request word (take, give back, read-and-clear peak)
// is decoded and placed in a two-word queue; the execute stage updates the ring
// and counters and registers the result word. Sustained rate is one word per
// cycle while the output register is not stalled, set by the execute stage's one
// ring access per word; each accepted request passes through a queue entry and
// then the output register. Writing a nonzero pool size refills the list in
// that same cycle and must only be done while no request is in flight.
module slot_free_list_allocator_top (
  input  logic       clk,
  input  logic       rst_n,
  sfl_in_if.sink     in_ch,
  sfl_cfg_if.sink    cfg_ch,
  sfl_out_if.source  out_ch
);

  logic          push_valid, push_ready;
  sfl_pkg::cmd_t push_cmd;
  logic          q_valid, q_ready;
  sfl_pkg::cmd_t q_cmd;

  sfl_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  sfl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  sfl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule
